### hw/rtl/sli_pkg.sv
// Shared types and codes for the sequential list block.
`timescale 1ns / 1ps

package sli_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [6:0]         position;
      logic signed [31:0] value;
   } sli_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic [6:0]         length_out;
   } sli_rsp_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } sli_state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_GET
   } sli_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_req;
      logic       load_rsp;
      sli_op_type op;
      logic [1:0] status;
   } sli_cmd_type;

   // Datapath to controller: decoded checks on the captured request.
   typedef struct packed {
      logic [1:0] cmd;
      logic       ins_bad;
      logic       full;
      logic       empty;
      logic       acc_bad;
   } sli_status_type;

endpackage

### hw/rtl/sli_ctrl.sv
// Controller state machine for the sequential list block.
`timescale 1ns / 1ps

module sli_ctrl
   import sli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  sli_status_type dp_status,
   output sli_cmd_type    dp_cmd
);

   sli_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      dp_cmd.load_req = 1'b0;
      dp_cmd.load_rsp = 1'b0;
      dp_cmd.op       = OP_NONE;
      dp_cmd.status   = ST_BADPOS;
      unique case (state_ff)
         S_IDLE: begin
            req_ready       = 1'b1;
            dp_cmd.load_req = req_valid;
         end
         S_EXEC: begin
            dp_cmd.load_rsp = out_free;
            unique case (dp_status.cmd)
               CMD_INSERT: begin
                  if (dp_status.ins_bad) begin
                     dp_cmd.status = ST_BADPOS;
                  end else if (dp_status.full) begin
                     dp_cmd.status = ST_FULL;
                  end else begin
                     dp_cmd.status = ST_OK;
                     dp_cmd.op     = OP_INSERT;
                  end
               end
               CMD_REMOVE: begin
                  if (dp_status.empty) begin
                     dp_cmd.status = ST_EMPTY;
                  end else if (dp_status.acc_bad) begin
                     dp_cmd.status = ST_BADPOS;
                  end else begin
                     dp_cmd.status = ST_OK;
                     dp_cmd.op     = OP_REMOVE;
                  end
               end
               CMD_GET: begin
                  if (!dp_status.acc_bad) begin
                     dp_cmd.status = ST_OK;
                     dp_cmd.op     = OP_GET;
                  end
               end
               default: begin
                  dp_cmd.status = ST_BADPOS;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/sli_dp.sv
// Datapath for the sequential list block: request register, shifting row, result register.
`timescale 1ns / 1ps

module sli_dp
   import sli_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic           clock,
   input  logic           reset,
   input  sli_req_type    req_data,
   input  sli_cmd_type    dp_cmd,
   output sli_status_type dp_status,
   output sli_rsp_type    rsp_data
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = ((LW > 7) ? LW : 7) + 1;

   sli_req_type        req_ff;
   sli_rsp_type        rsp_ff;
   logic [LW-1:0]      len_ff, len_in;
   logic signed [31:0] elem_ff [DEPTH];
   logic signed [31:0] elem_in [DEPTH];
   logic signed [31:0] up      [DEPTH];
   logic signed [31:0] dn      [DEPTH];

   logic [CW-1:0]      pos_w, len_w, idx_w, len_nxt;
   logic [IW-1:0]      idx;
   logic signed [31:0] rd;
   logic               row_wr;

   assign pos_w = CW'(req_ff.position);
   assign len_w = CW'(len_ff);
   assign idx_w = pos_w - CW'(1);
   assign idx   = idx_w[IW-1:0];

   assign dp_status.cmd     = req_ff.cmd;
   assign dp_status.ins_bad = (pos_w == '0) || (pos_w > (len_w + CW'(1)));
   assign dp_status.full    = (len_w == CW'(DEPTH));
   assign dp_status.empty   = (len_ff == '0);
   assign dp_status.acc_bad = (pos_w == '0) || (pos_w > len_w);

   always_comb begin
      case (dp_cmd.op)
         OP_INSERT: len_nxt = len_w + CW'(1);
         OP_REMOVE: len_nxt = len_w - CW'(1);
         default:   len_nxt = len_w;
      endcase
   end
   assign len_in = len_nxt[LW-1:0];

   assign rd     = elem_ff[idx];
   assign row_wr = dp_cmd.load_rsp && ((dp_cmd.op == OP_INSERT) || (dp_cmd.op == OP_REMOVE));

   // Neighbor views of the row: each cell sees the one below and the one above it.
   always_comb begin
      up[0]       = elem_ff[0];
      dn[DEPTH-1] = elem_ff[DEPTH-1];
      for (int k = 1; k < DEPTH; k++) begin
         up[k] = elem_ff[k-1];
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
         dn[k] = elem_ff[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         elem_in[k] = elem_ff[k];
         if (dp_cmd.op == OP_INSERT) begin
            if (IW'(k) > idx) begin
               elem_in[k] = up[k];
            end else if (IW'(k) == idx) begin
               elem_in[k] = req_ff.value;
            end
         end else if (dp_cmd.op == OP_REMOVE) begin
            if (IW'(k) >= idx) begin
               elem_in[k] = dn[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (dp_cmd.load_rsp) begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         req_ff <= req_data;
      end
      if (dp_cmd.load_rsp) begin
         rsp_ff.status     <= dp_cmd.status;
         rsp_ff.value_out  <= ((dp_cmd.op == OP_REMOVE) || (dp_cmd.op == OP_GET)) ? rd : '0;
         rsp_ff.length_out <= len_nxt[6:0];
      end
      if (row_wr) begin
         for (int k = 0; k < DEPTH; k++) begin
            elem_ff[k] <= elem_in[k];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hw/rtl/sequential_list_insert_remove.sv
// Top level of the sequential list block: controller, datapath and checks.
`timescale 1ns / 1ps

// An ordered list of up to DEPTH signed 32-bit values addressed by 1-based
// positions. Each request item inserts, removes or reads one entry and gives
// exactly one result item with a status, the removed or read value, and the
// list length after the operation (low seven bits). The list lives in a row of
// register cells, so an insert or remove shifts the entries from the given
// position to the top of the row at once. An item is first captured in the
// request register; an execute step then checks it, shifts the row and loads
// the result register. The request side is ready again as soon as the result
// is loaded, even while that result still waits to be taken; the execute step
// itself waits only if the previous result has not left. Entries above the
// current length are never read by a legal request and hold no defined value.

module sequential_list_insert_remove
   import sli_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sli_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sli_rsp_type rsp_data
);

   sli_cmd_type    dp_cmd;
   sli_status_type dp_status;

   // Sequencing of capture and execute, and the result valid flag.
   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Storage, checks and the shifting row.
   sli_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

   // A result is never loaded over one that has not yet been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a result was pending");

   // A loaded result is offered in the following cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |=> rsp_valid)
      else $error("loaded result not offered");

   // Only one request is in flight: after an accept the request side closes.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request side open while a request is executing");

   // A failed request never touches the list.
   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.load_rsp && (dp_cmd.status != ST_OK)) |-> (dp_cmd.op == OP_NONE))
      else $error("failed request changed the list");

endmodule

### dv/sequential_list_insert_remove_tb.sv
// Self-checking testbench for the sequential list insert/remove block.
`timescale 1ns / 1ps

module sequential_list_insert_remove_tb;
   import sli_pkg::*;

   localparam int DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASE_ITEMS = 120;

   // The package names the three real commands only; code 3 is the unused one.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum {
      TREND_GROW,
      TREND_SHRINK,
      TREND_MIX
   } trend_type;

   // One row of the directed table. Rows with a typed answer are checked
   // against that answer; the others are checked against the list mirror.
   typedef struct {
      sli_req_type req;
      bit          typed;
      sli_rsp_type want;
   } plan_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sli_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sli_rsp_type rsp_data;

   // Mirror of the list: entry contents and the element count.
   logic signed [31:0] slots [DEPTH];
   int                 fill = 0;
   int                 peak_fill = 0;

   sli_rsp_type  answer_q [$];
   plan_row_type plan_q [$];

   int  errors = 0;
   int  items_sent = 0;
   int  directed_items = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   bit  calm = 1'b0;

   sequential_list_insert_remove #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one request to the mirror and returns the answer it must give.
   // Insert checks the position before the full condition; remove checks for
   // an empty list before the position. Failed requests leave the list alone.
   function automatic sli_rsp_type list_apply(input sli_req_type r);
      sli_rsp_type a;
      int          p;
      a.status = ST_BADPOS;
      a.value_out = '0;
      p = int'(r.position);
      case (r.cmd)
         CMD_INSERT: begin
            if (p != 0 && p <= fill + 1) begin
               if (fill >= DEPTH) begin
                  a.status = ST_FULL;
               end else begin
                  // The entry at the insert point moves up together with the rest.
                  for (int k = fill; k >= p; k--) slots[k] = slots[k - 1];
                  slots[p - 1] = r.value;
                  fill++;
                  a.status = ST_OK;
               end
            end
         end
         CMD_REMOVE: begin
            if (fill == 0) begin
               a.status = ST_EMPTY;
            end else if (p != 0 && p <= fill) begin
               a.value_out = slots[p - 1];
               for (int k = p - 1; k + 1 < fill; k++) slots[k] = slots[k + 1];
               slots[fill - 1] = '0;
               fill--;
               a.status = ST_OK;
            end
         end
         CMD_GET: begin
            if (p != 0 && p <= fill) begin
               a.value_out = slots[p - 1];
               a.status = ST_OK;
            end
         end
         default: begin
         end
      endcase
      a.length_out = 7'(fill);
      if (fill > peak_fill) peak_fill = fill;
      return a;
   endfunction

   function automatic sli_req_type make_item(input logic [1:0] cmd, input logic [6:0] pos,
                                             input logic [31:0] val);
      sli_req_type r;
      r.cmd = cmd;
      r.position = pos;
      r.value = val;
      return r;
   endfunction

   function automatic sli_rsp_type make_answer(input logic [1:0] st, input logic [31:0] v,
                                               input logic [6:0] len);
      sli_rsp_type a;
      a.status = st;
      a.value_out = v;
      a.length_out = len;
      return a;
   endfunction

   function automatic void plan(input logic [1:0] cmd, input logic [6:0] pos,
                                input logic [31:0] val, input bit typed,
                                input logic [1:0] st, input logic [31:0] v,
                                input logic [6:0] len);
      plan_row_type row;
      row.req = make_item(cmd, pos, val);
      row.typed = typed;
      row.want = make_answer(st, v, len);
      plan_q.push_back(row);
   endfunction

   // Length of an idle stretch: mostly none or short, now and then long.
   // During a calm phase neither side idles at all.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   // Presents one request item and holds it until the block takes it. The
   // mirror is updated at the accepting edge. Valid is lowered only when a gap
   // follows, so a back-to-back item never sees valid dropped and raised in
   // the same time step.
   task automatic send(input sli_req_type r, input bit typed, input sli_rsp_type want);
      sli_rsp_type predicted;
      int          gap;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = list_apply(r);
      answer_q.push_back(typed ? want : predicted);
      items_sent++;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_predicted(input sli_req_type r);
      send(r, 1'b0, '0);
   endtask

   // Position for a random item: mostly a legal one, sometimes zero, one past
   // the legal end, or anything the field can hold.
   function automatic logic [6:0] pick_position(input logic [1:0] cmd);
      int hi;
      int r;
      hi = (cmd == CMD_INSERT) ? fill + 1 : fill;
      r = $urandom_range(0, 99);
      if (r < 78) begin
         if (hi == 0) return 7'd1;
         if (r < 8) return 7'd1;
         if (r < 16) return 7'(hi);
         return 7'($urandom_range(1, hi));
      end
      if (r < 84) return 7'd0;
      if (r < 92) return (hi + 1 > 127) ? 7'd127 : 7'(hi + 1);
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic logic [1:0] pick_command(input trend_type trend);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return CMD_UNUSED;
      case (trend)
         TREND_GROW:   return (r < 75) ? CMD_INSERT : (r < 90) ? CMD_GET : CMD_REMOVE;
         TREND_SHRINK: return (r < 20) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : CMD_GET;
         default:      return (r < 40) ? CMD_INSERT : (r < 75) ? CMD_REMOVE : CMD_GET;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("MISMATCH at result %0d: %s expected %0h, got %0h", results_seen, what, want, got);
   endtask

   // Result side: the ready line alternates between short busy bursts and
   // stalls of random length, drawn from the same idle profile as the sender.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = idle_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Every accepted result is compared, field by field, with the oldest
   // expectation still waiting.
   always @(posedge clock) begin : check_results
      sli_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            report("result with nothing outstanding, status", '0, 32'(rsp_data.status));
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.status !== want.status)
               report("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.value_out !== want.value_out)
               report("value_out", want.value_out, rsp_data.value_out);
            if (rsp_data.length_out !== want.length_out)
               report("length_out", 32'(want.length_out), 32'(rsp_data.length_out));
         end
         status_seen[rsp_data.status]++;
         results_seen++;
      end
   end

   // A run in which neither channel moves for a long stretch has hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, answer_q.size());
         $display("sequential_list_insert_remove regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      trend_type   trend;
      logic [1:0]  cmd;
      sli_req_type r;

      foreach (slots[i]) slots[i] = '0;

      // Directed table. The opening rows probe an empty list, the position
      // and command checks and the value extremes; the later ones shift
      // entries around a middle insert and are checked against the mirror.
      plan(CMD_GET,    7'd1,   32'h0,         1, ST_BADPOS, 32'h0,         7'd0);
      plan(CMD_REMOVE, 7'd1,   32'h0,         1, ST_EMPTY,  32'h0,         7'd0);
      plan(CMD_REMOVE, 7'd0,   32'h0,         1, ST_EMPTY,  32'h0,         7'd0);
      plan(CMD_INSERT, 7'd0,   32'h5,         1, ST_BADPOS, 32'h0,         7'd0);
      plan(CMD_INSERT, 7'd2,   32'h5,         1, ST_BADPOS, 32'h0,         7'd0);
      plan(CMD_UNUSED, 7'd1,   32'h9,         1, ST_BADPOS, 32'h0,         7'd0);
      plan(CMD_INSERT, 7'd1,   32'h7FFF_FFFF, 1, ST_OK,     32'h0,         7'd1);
      plan(CMD_INSERT, 7'd1,   32'h8000_0000, 1, ST_OK,     32'h0,         7'd2);
      plan(CMD_INSERT, 7'd3,   32'hFFFF_FFFF, 1, ST_OK,     32'h0,         7'd3);
      plan(CMD_GET,    7'd1,   32'h0,         1, ST_OK,     32'h8000_0000, 7'd3);
      plan(CMD_GET,    7'd2,   32'h0,         1, ST_OK,     32'h7FFF_FFFF, 7'd3);
      plan(CMD_GET,    7'd3,   32'h0,         1, ST_OK,     32'hFFFF_FFFF, 7'd3);
      plan(CMD_GET,    7'd4,   32'h0,         1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_GET,    7'd0,   32'h0,         1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_REMOVE, 7'd0,   32'h0,         1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_REMOVE, 7'd4,   32'h0,         1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_INSERT, 7'd5,   32'h1,         1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_INSERT, 7'd127, 32'hFFFF_FFFF, 1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_UNUSED, 7'd127, 32'hFFFF_FFFF, 1, ST_BADPOS, 32'h0,         7'd3);
      plan(CMD_INSERT, 7'd2,   32'h5A5A_5A5A, 0, ST_OK,     32'h0,         7'd0);
      plan(CMD_GET,    7'd3,   32'h0,         0, ST_OK,     32'h0,         7'd0);
      plan(CMD_REMOVE, 7'd2,   32'h0,         0, ST_OK,     32'h0,         7'd0);
      plan(CMD_REMOVE, 7'd1,   32'h0,         0, ST_OK,     32'h0,         7'd0);
      plan(CMD_GET,    7'd1,   32'h0,         0, ST_OK,     32'h0,         7'd0);
      plan(CMD_REMOVE, 7'd1,   32'h0,         0, ST_OK,     32'h0,         7'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_q[i]) send(plan_q[i].req, plan_q[i].typed, plan_q[i].want);

      // Fill the list to capacity, then check that a full list refuses an
      // insert, yet still reports a bad position first where there is one.
      while (fill < DEPTH)
         send_predicted(make_item(CMD_INSERT, 7'($urandom_range(1, fill + 1)), pick_value()));
      send(make_item(CMD_INSERT, 7'd65, 32'h1), 1, make_answer(ST_FULL, 32'h0, 7'd64));
      send(make_item(CMD_INSERT, 7'd1, 32'h1), 1, make_answer(ST_FULL, 32'h0, 7'd64));
      send(make_item(CMD_INSERT, 7'd0, 32'h1), 1, make_answer(ST_BADPOS, 32'h0, 7'd64));
      send(make_item(CMD_INSERT, 7'd66, 32'h1), 1, make_answer(ST_BADPOS, 32'h0, 7'd64));
      send(make_item(CMD_GET, 7'd65, 32'h0), 1, make_answer(ST_BADPOS, 32'h0, 7'd64));
      send(make_item(CMD_REMOVE, 7'd65, 32'h0), 1, make_answer(ST_BADPOS, 32'h0, 7'd64));
      send_predicted(make_item(CMD_GET, 7'd64, 32'h0));
      send_predicted(make_item(CMD_REMOVE, 7'd64, 32'h0));

      // Drain it again from random places down to empty.
      while (fill > 0)
         send_predicted(make_item(CMD_REMOVE, 7'($urandom_range(1, fill)), 32'h0));
      send(make_item(CMD_REMOVE, 7'd1, 32'h0), 1, make_answer(ST_EMPTY, 32'h0, 7'd0));
      directed_items = items_sent;

      // Random part. Each phase leans toward growing, shrinking or churning
      // the list; some phases run with no idling on either side.
      trend = TREND_GROW;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            trend = trend_type'($urandom_range(0, 2));
            calm = ($urandom_range(0, 3) == 0);
         end
         cmd = pick_command(trend);
         r = make_item(cmd, pick_position(cmd), pick_value());
         send_predicted(r);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Let every outstanding result drain, then wait for anything stray;
      // the watchdog bounds this wait.
      while (answer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d items (%0d directed) and %0d results; list peaked at %0d of %0d.",
               items_sent, directed_items, results_seen, peak_fill, DEPTH);
      $display("Statuses seen: ok %0d, bad position %0d, full %0d, empty %0d; mismatches %0d.",
               status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
               status_seen[ST_EMPTY], errors);
      if (errors == 0) begin
         $display("sequential_list_insert_remove regression: pass");
      end else begin
         $display("sequential_list_insert_remove regression: fail");
      end
      $finish;
   end

endmodule
